/* rtl/i2cee_pkg.sv */
// Shared types and constants for the I2C EEPROM byte master.
`timescale 1ns / 1ps
`default_nettype none

package i2cee_pkg;

  // Configuration register indexes
  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_HALF_PERIOD    = 1'b1;

  localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd80;
  localparam logic [7:0] HALF_PERIOD_RESET    = 8'd5;

  // Read/write bit appended to the device address
  localparam logic RW_WRITE = 1'b0;
  localparam logic RW_READ  = 1'b1;

  // Operation selector
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  localparam int BITS_PER_BYTE = 8;

  // Input item, last field in the lowest bits
  typedef struct packed {
    logic [4:0] pad;
    logic       sda_in;
    logic [7:0] write_data;
    logic [7:0] word_address;
    logic       func;
    logic       start_request;
  } in_item_t;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic [2:0] pad;
    logic [7:0] read_data;
    logic       status;
    logic       done_res;
    logic       busy_res;
    logic       sda_pull_low;
    logic       scl_level;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/i2c_eeprom_byte_master.sv */
// I2C EEPROM byte master: byte write and random byte read, one tick per transaction.
//
// Usage: every input transaction on in_* is one bus tick. It carries a start
// request, the operation (write or random read), the word address, the write
// data and the sampled SDA level. Every accepted tick yields exactly one result
// on out_*: SCL level, SDA pull-low, busy, a one-tick done strobe, status
// (1 = no acknowledge) and the byte read.
// The configuration port sets the 7-bit device address (index 0) and the
// number of ticks per SCL half period and START/STOP interval (index 1, 0
// acts as 1); write it only while no transfer runs.
// The result of a tick is registered and appears on out_* in the cycle after in_*
// accepts it. Throughput: one tick per cycle while out_tready allows; the sequencer
// state and the output register both update in the cycle of acceptance.
// Reset: the sequencer goes idle, the device address returns to 80 and the
// half period to 5; in_tready is low while rst_n is low.
// Stall: when out_tready is low a pending result holds in the output register
// and in_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module i2c_eeprom_byte_master
  import i2cee_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // start_request, func, word_address, write_data, sda_in listed from bit 0 up:
  // start_request, func, word_address[9:2], write_data[17:10], sda_in[18], zeros
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,
  // scl_level, sda_pull_low, busy_res, done_res, status, read_data[12:5], zeros
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_START_SETUP, PH_START_HOLD, PH_TX_LOW, PH_TX_HIGH,
    PH_ACK_LOW, PH_ACK_HIGH, PH_RS_LOW, PH_RS_SETUP, PH_RS_HOLD,
    PH_RX_LOW, PH_RX_HIGH, PH_NACK_LOW, PH_NACK_HIGH, PH_STOP_LOW,
    PH_STOP_SETUP, PH_STOP_HOLD, PH_DONE
  } phase_t;

  logic [6:0] dev_addr_r;
  logic [7:0] half_period_r;

  phase_t     phase_r, phase_nxt;
  logic [3:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] tick_div_r, tick_div_nxt;
  logic       lat_op_r, lat_op_nxt;
  logic [7:0] lat_addr_r, lat_addr_nxt;
  logic [7:0] lat_data_r, lat_data_nxt;
  logic       last_status_r, last_status_nxt;
  logic [1:0] byte_stage_r, byte_stage_nxt;

  logic       out_valid_r;
  out_item_t  out_item_r, out_item_nxt;

  in_item_t   in_item;
  logic       in_accept;
  logic       launch;
  logic       nack;
  logic [7:0] half_eff;
  logic [8:0] tick_inc;
  logic [3:0] bit_inc;

  assign in_item   = in_item_t'(in_tdata);
  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign in_accept = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r;

  assign half_eff = (half_period_r == 8'd0) ? 8'd1 : half_period_r;
  assign launch   = ((phase_r == PH_IDLE) || (phase_r == PH_DONE)) && in_item.start_request;
  assign nack     = in_item.sda_in;

  always_comb begin
    phase_nxt       = phase_r;
    bit_cnt_nxt     = bit_cnt_r;
    shift_nxt       = shift_r;
    tick_div_nxt    = tick_div_r;
    lat_op_nxt      = lat_op_r;
    lat_addr_nxt    = lat_addr_r;
    lat_data_nxt    = lat_data_r;
    last_status_nxt = last_status_r;
    byte_stage_nxt  = byte_stage_r;

    // Latch a new transfer first; this tick's outputs belong to it
    if (launch) begin
      lat_op_nxt      = in_item.func;
      lat_addr_nxt    = in_item.word_address;
      lat_data_nxt    = in_item.write_data;
      last_status_nxt = 1'b0;
      tick_div_nxt    = 8'd0;
      bit_cnt_nxt     = 4'd0;
      byte_stage_nxt  = 2'd0;
      shift_nxt       = {dev_addr_r, RW_WRITE};
      phase_nxt       = PH_START_SETUP;
    end

    out_item_nxt              = '0;
    out_item_nxt.scl_level    = 1'b1;
    out_item_nxt.busy_res     = 1'b1;
    unique case (phase_nxt)
      PH_IDLE, PH_DONE: begin
        out_item_nxt.busy_res  = 1'b0;
        out_item_nxt.done_res  = (phase_nxt == PH_DONE);
        out_item_nxt.status    = last_status_nxt;
        out_item_nxt.read_data = shift_nxt;
      end
      PH_START_HOLD, PH_RS_HOLD, PH_STOP_SETUP: out_item_nxt.sda_pull_low = 1'b1;
      PH_TX_LOW: begin
        out_item_nxt.scl_level    = 1'b0;
        out_item_nxt.sda_pull_low = !shift_nxt[7];
      end
      PH_TX_HIGH: out_item_nxt.sda_pull_low = !shift_nxt[7];
      PH_ACK_LOW, PH_RS_LOW, PH_RX_LOW, PH_NACK_LOW: out_item_nxt.scl_level = 1'b0;
      PH_STOP_LOW: begin
        out_item_nxt.scl_level    = 1'b0;
        out_item_nxt.sda_pull_low = 1'b1;
      end
      default: ;
    endcase

    tick_inc = {1'b0, tick_div_nxt} + 9'd1;
    bit_inc  = bit_cnt_nxt + 4'd1;

    if (phase_nxt == PH_DONE) begin
      phase_nxt = PH_IDLE;
    end else if (phase_nxt != PH_IDLE) begin
      if (tick_inc < {1'b0, half_eff}) begin
        tick_div_nxt = tick_inc[7:0];
      end else begin
        tick_div_nxt = 8'd0;
        unique case (phase_nxt)
          PH_START_SETUP: phase_nxt = PH_START_HOLD;
          PH_START_HOLD: begin
            phase_nxt   = PH_TX_LOW;
            bit_cnt_nxt = 4'd0;
          end
          PH_TX_LOW: phase_nxt = PH_TX_HIGH;
          PH_TX_HIGH: begin
            shift_nxt   = {shift_nxt[6:0], 1'b0};
            bit_cnt_nxt = bit_inc;
            phase_nxt   = (bit_inc >= 4'(BITS_PER_BYTE)) ? PH_ACK_LOW : PH_TX_LOW;
          end
          PH_ACK_LOW: phase_nxt = PH_ACK_HIGH;
          PH_ACK_HIGH: begin
            // Word address ACK is ignored on a read: go to repeated START
            if (byte_stage_nxt == 2'd1 && lat_op_nxt == FUNC_READ) begin
              phase_nxt = PH_RS_LOW;
            end else if (nack) begin
              last_status_nxt = 1'b1;
              shift_nxt       = 8'd0;
              phase_nxt       = PH_STOP_LOW;
            end else begin
              unique case (byte_stage_nxt)
                2'd0: begin
                  shift_nxt      = lat_addr_nxt;
                  byte_stage_nxt = 2'd1;
                  bit_cnt_nxt    = 4'd0;
                  phase_nxt      = PH_TX_LOW;
                end
                2'd1: begin
                  shift_nxt      = lat_data_nxt;
                  byte_stage_nxt = 2'd2;
                  bit_cnt_nxt    = 4'd0;
                  phase_nxt      = PH_TX_LOW;
                end
                2'd2: begin
                  last_status_nxt = 1'b0;
                  shift_nxt       = 8'd0;
                  phase_nxt       = PH_STOP_LOW;
                end
                2'd3: begin
                  shift_nxt   = 8'd0;
                  bit_cnt_nxt = 4'd0;
                  phase_nxt   = PH_RX_LOW;
                end
              endcase
            end
          end
          PH_RS_LOW:   phase_nxt = PH_RS_SETUP;
          PH_RS_SETUP: phase_nxt = PH_RS_HOLD;
          PH_RS_HOLD: begin
            shift_nxt      = {dev_addr_r, RW_READ};
            byte_stage_nxt = 2'd3;
            bit_cnt_nxt    = 4'd0;
            phase_nxt      = PH_TX_LOW;
          end
          PH_RX_LOW: phase_nxt = PH_RX_HIGH;
          PH_RX_HIGH: begin
            shift_nxt   = {shift_nxt[6:0], in_item.sda_in};
            bit_cnt_nxt = bit_inc;
            phase_nxt   = (bit_inc >= 4'(BITS_PER_BYTE)) ? PH_NACK_LOW : PH_RX_LOW;
          end
          PH_NACK_LOW:   phase_nxt = PH_NACK_HIGH;
          PH_NACK_HIGH:  phase_nxt = PH_STOP_LOW;
          PH_STOP_LOW:   phase_nxt = PH_STOP_SETUP;
          PH_STOP_SETUP: phase_nxt = PH_STOP_HOLD;
          PH_STOP_HOLD:  phase_nxt = PH_DONE;
          default:       phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r    <= DEVICE_ADDRESS_RESET;
      half_period_r <= HALF_PERIOD_RESET;
      phase_r       <= PH_IDLE;
      bit_cnt_r     <= 4'd0;
      shift_r       <= 8'd0;
      tick_div_r    <= 8'd0;
      lat_op_r      <= 1'b0;
      lat_addr_r    <= 8'd0;
      lat_data_r    <= 8'd0;
      last_status_r <= 1'b0;
      byte_stage_r  <= 2'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEVICE_ADDRESS: dev_addr_r    <= cfg_data[6:0];
          CFG_HALF_PERIOD:    half_period_r <= cfg_data;
        endcase
      end
      if (in_accept) begin
        phase_r       <= phase_nxt;
        bit_cnt_r     <= bit_cnt_nxt;
        shift_r       <= shift_nxt;
        tick_div_r    <= tick_div_nxt;
        lat_op_r      <= lat_op_nxt;
        lat_addr_r    <= lat_addr_nxt;
        lat_data_r    <= lat_data_nxt;
        last_status_r <= last_status_nxt;
        byte_stage_r  <= byte_stage_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_tready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= 4'(BITS_PER_BYTE))
    else $error("bit counter past one byte");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && phase_r == PH_DONE && !in_item.start_request |=> phase_r == PH_IDLE)
    else $error("done tick not followed by idle");

  a_launch_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && launch |=> phase_r != PH_IDLE && phase_r != PH_DONE && out_item_r.busy_res)
    else $error("start request did not launch a transfer");

  a_busy_hides_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.busy_res |-> !out_item_r.status && out_item_r.read_data == 8'd0
      && !out_item_r.done_res)
    else $error("result fields shown while busy");

endmodule

`default_nettype wire
